// File: design/lsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and codes of the LIFO stack allocator
// Holds the request and response item layouts, the stack record layout,
// the operation and status codes and the fixed datapath widths.
// ----------------------------------------------------------------------------
package lsa_pkg;

   // Width of the internal offset arithmetic. This is wide enough for the
   // fill offset plus header, worst-case padding and the largest size.
   localparam int DpWidth = 24;

   localparam int SizeWidth   = 21;
   localparam int OffsetWidth = 20;
   localparam int AlignWidth  = 4;

   // Largest supported alignment exponent.
   localparam logic [AlignWidth-1:0] MAX_ALIGN_LOG2 = 4'd12;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_ALLOCATED    = 2'd0;
   localparam logic [1:0] ST_ALLOC_REJECT = 2'd1;
   localparam logic [1:0] ST_FREED        = 2'd2;
   localparam logic [1:0] ST_FREE_IGNORED = 2'd3;

   // Reset value of the arena capacity register.
   localparam logic [SizeWidth-1:0] ARENA_RESET = 21'h100000;

   typedef struct packed {
      logic                   opcode;
      logic [SizeWidth-1:0]   request_bytes;
      logic [AlignWidth-1:0]  align_log2;
      logic [OffsetWidth-1:0] data_offset;
   } lsa_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [OffsetWidth-1:0] granted_offset;
      logic [SizeWidth-1:0]   top_offset;
      logic [SizeWidth-1:0]   used_bytes;
   } lsa_rsp_type;

   // One live allocation: where it started and how many bytes it asked for.
   typedef struct packed {
      logic [SizeWidth-1:0] start;
      logic [SizeWidth-1:0] size;
   } lsa_rec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request item
      logic commit;    // load the response register
      logic push;      // record a new allocation
      logic pop;       // release the most recent allocation
   } lsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alloc_ok;  // the held request is an allocate that fits
      logic free_ok;   // the held request is a free that matches the top
   } lsa_stat_type;

endpackage : lsa_pkg
`default_nettype wire

// File: design/lsa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_req_if: request channel of the LIFO stack allocator
// Valid/ready channel carrying one allocate or free item.
// ----------------------------------------------------------------------------
interface lsa_req_if
   import lsa_pkg::*;
   ();

   logic        valid;
   logic        ready;
   lsa_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface : lsa_req_if
`default_nettype wire

// File: design/lsa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_rsp_if: response channel of the LIFO stack allocator
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface lsa_rsp_if
   import lsa_pkg::*;
   ();

   logic        valid;
   logic        ready;
   lsa_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface : lsa_rsp_if
`default_nettype wire

// File: design/lsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_ctrl: controller of the LIFO stack allocator
// Two-state sequencer that accepts a request, evaluates it once the
// response register is free, and owns the response valid flag.
// ----------------------------------------------------------------------------
module lsa_ctrl
   import lsa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire lsa_stat_type stat,
   output lsa_cmd_type       cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EVAL = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.capture = req_valid && req_ready;
      cmd.commit  = (state_ff == S_EVAL) && out_free;
      cmd.push    = cmd.commit && stat.alloc_ok;
      cmd.pop     = cmd.commit && stat.free_ok;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A committed evaluation always presents a response on the next cycle.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise the response valid flag");

   // The datapath never reports a fitting allocate and a matching free at once.
   a_stat_excl: assert property (@(posedge clock) disable iff (reset)
      !(stat.alloc_ok && stat.free_ok))
      else $error("allocate and free both reported successful");

   // Every accepted item puts the controller in its evaluate state in the following cycle.
   a_capture_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_EVAL))
      else $error("accepted item was not evaluated");

endmodule : lsa_ctrl
`default_nettype wire

// File: design/lsa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_dp: datapath of the LIFO stack allocator
// Holds the capacity register, fill offset, live byte total, the record
// stack memory and the response register, and evaluates one request.
// ----------------------------------------------------------------------------
module lsa_dp
   import lsa_pkg::*;
#(
   parameter int HEADER_BYTES = 8,
   parameter int MAX_LIVE     = 64,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [SizeWidth-1:0] csr_wdata,
   input  wire lsa_req_type          req_item,
   input  wire lsa_cmd_type          cmd,
   output lsa_stat_type              stat,
   output lsa_rsp_type               rsp_item
);

   localparam int CntWidth = $clog2(MAX_LIVE + 1);
   localparam int IdxWidth = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
   // The arena register never exceeds 2^21, so any limit at or above 2^22
   // behaves the same as no limit at all.
   localparam int LimLog2 = (ADDR_BITS > 22) ? 22 : ADDR_BITS;
   localparam logic [DpWidth-1:0] ADDR_LIMIT = DpWidth'(1) << LimLog2;
   localparam logic [DpWidth-1:0] HDR_LEN    = DpWidth'(HEADER_BYTES);

   logic [SizeWidth-1:0] arena_ff;
   logic [SizeWidth-1:0] fill_ff;
   logic [SizeWidth-1:0] fill_in;
   logic [SizeWidth-1:0] live_ff;
   logic [SizeWidth-1:0] live_in;
   logic [CntWidth-1:0]  count_ff;
   logic [CntWidth-1:0]  count_in;
   lsa_req_type          req_ff;
   lsa_rec_type          rec_rd_ff;
   lsa_rsp_type          rsp_ff;
   lsa_rsp_type          rsp_in;

   lsa_rec_type rec_mem [MAX_LIVE];

   logic [CntWidth-1:0]  count_dec;
   logic [IdxWidth-1:0]  top_idx;
   logic [IdxWidth-1:0]  push_idx;
   logic [DpWidth-1:0]   capacity;
   logic [DpWidth-1:0]   after_hdr;
   logic [DpWidth-1:0]   align_mask;
   logic [DpWidth-1:0]   aligned;
   logic [DpWidth-1:0]   alloc_end;
   logic                 alloc_legal;
   logic [SizeWidth:0]   free_sum;

   assign count_dec = count_ff - CntWidth'(1);
   assign top_idx   = count_dec[IdxWidth-1:0];
   assign push_idx  = count_ff[IdxWidth-1:0];

   assign capacity = ({3'b000, arena_ff} < ADDR_LIMIT) ? {3'b000, arena_ff} : ADDR_LIMIT;

   // Allocate: header after the fill offset, round up, then the data.
   assign after_hdr   = {3'b000, fill_ff} + HDR_LEN;
   assign align_mask  = (DpWidth'(1) << req_ff.align_log2) - DpWidth'(1);
   assign aligned     = (after_hdr + align_mask) & ~align_mask;
   assign alloc_end   = aligned + {3'b000, req_ff.request_bytes};
   assign alloc_legal = (req_ff.request_bytes != '0) &&
                        (req_ff.align_log2 <= MAX_ALIGN_LOG2) &&
                        (count_ff < CntWidth'(MAX_LIVE));

   // Free: the block must end exactly at the fill offset.
   assign free_sum = {2'b00, req_ff.data_offset} + {1'b0, rec_rd_ff.size};

   always_comb begin
      stat.alloc_ok = (req_ff.opcode == OP_ALLOC) && alloc_legal &&
                      (alloc_end <= capacity);
      stat.free_ok  = (req_ff.opcode == OP_FREE) && (count_ff != '0) &&
                      (free_sum == {1'b0, fill_ff});
   end

   always_comb begin
      fill_in  = fill_ff;
      live_in  = live_ff;
      count_in = count_ff;
      if (cmd.push) begin
         fill_in  = alloc_end[SizeWidth-1:0];
         live_in  = live_ff + req_ff.request_bytes;
         count_in = count_ff + CntWidth'(1);
      end else if (cmd.pop) begin
         fill_in  = rec_rd_ff.start;
         live_in  = live_ff - rec_rd_ff.size;
         count_in = count_dec;
      end
   end

   always_comb begin
      rsp_in.granted_offset = '0;
      if (req_ff.opcode == OP_ALLOC) begin
         if (stat.alloc_ok) begin
            rsp_in.status         = ST_ALLOCATED;
            rsp_in.granted_offset = aligned[OffsetWidth-1:0];
         end else begin
            rsp_in.status = ST_ALLOC_REJECT;
         end
      end else begin
         rsp_in.status = stat.free_ok ? ST_FREED : ST_FREE_IGNORED;
      end
      rsp_in.top_offset = fill_in;
      rsp_in.used_bytes = live_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff <= ARENA_RESET;
         fill_ff  <= '0;
         live_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            arena_ff <= csr_wdata;
         end
         fill_ff  <= fill_in;
         live_ff  <= live_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Record stack: one write port, one registered read of the top entry.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rec_mem[push_idx] <= '{start: fill_ff, size: req_ff.request_bytes};
      end
      rec_rd_ff <= rec_mem[top_idx];
   end

   assign rsp_item = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(MAX_LIVE))
      else $error("record count above the stack depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (count_ff == $past(count_ff) + CntWidth'(1)))
      else $error("allocation did not grow the record stack");

   a_fill_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> ({3'b000, fill_ff} <= $past(capacity)))
      else $error("fill offset beyond usable capacity after allocation");

endmodule : lsa_dp
`default_nettype wire

// File: design/lifo_stack_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_allocator: bump allocator over a byte arena with LIFO free
// An allocate places a header at the fill offset, aligns the data to a
// power of two and bumps the fill offset if everything fits; a free of the
// most recent allocation rolls the fill offset back to that allocation's
// start. One response item is returned for every request item.
//
//   Channel    Direction  Handshake        Carries
//   req_bus    in         valid / ready    opcode, size, alignment, offset
//   rsp_bus    out        valid / ready    status, granted, top, used bytes
//   csr_*      in         write enable     arena capacity in bytes
//
// Each item is first accepted while the top record of the stack memory is
// read into a register, then evaluated, which loads the response register.
// The registered read of the record stack memory is the reason for this split.
// After reset the arena is 1048576 bytes and no allocation is live; the
// record memory needs no clearing since only live entries are used.
// A response waiting on rsp_bus does not block accepting the next item;
// the evaluation of that item waits until the response register is free.
// ----------------------------------------------------------------------------
module lifo_stack_allocator
   import lsa_pkg::*;
#(
   parameter int HEADER_BYTES = 8,
   parameter int MAX_LIVE     = 64,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lsa_req_if.sink                   req_bus,
   lsa_rsp_if.source                 rsp_bus,
   input  wire logic                 csr_we,
   input  wire logic [SizeWidth-1:0] csr_wdata
);

   // Commands flow from the sequencer to the datapath, outcomes flow back.
   lsa_cmd_type  cmd;
   lsa_stat_type stat;
   logic         req_ready;
   logic         rsp_valid;

   lsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lsa_dp #(
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_LIVE     (MAX_LIVE),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_item  (req_bus.payload),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_bus.payload)
   );

   // The handshake flags live in the controller; the payload register lives
   // in the datapath and only changes when the controller commits.
   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule : lifo_stack_allocator
`default_nettype wire

// File: tb/tb_lifo_stack_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_allocator: self-checking bench for the LIFO stack allocator
// Drives allocate and free items through the request channel, keeps its own
// model of the fill offset, live byte count and allocation record stack, and
// compares every response item with the model's prediction. The run covers
// the corner cases, a full record stack, several arena capacities,
// back-pressure and random traffic under different idle and stall rates.
// ----------------------------------------------------------------------------
module tb_lifo_stack_allocator;
   import lsa_pkg::*;

   // Allocator configuration; the model below assumes the same values.
   localparam int HdrBytes = 8;
   localparam int MaxLive  = 64;
   localparam int AddrBits = 20;

   // Cycles to wait after the last response before a register write or the
   // end of the run.
   localparam int SettleCycles = 8;

   // Hard ceiling for the whole run, far above the slowest correct run.
   localparam longint TimeoutNs = 64'd5_000_000;

   localparam longint unsigned Mask21 = 64'h1F_FFFF;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [SizeWidth-1:0] csr_wdata;

   lsa_req_if req_bus ();
   lsa_rsp_if rsp_bus ();

   lifo_stack_allocator #(
      .HEADER_BYTES (HdrBytes),
      .MAX_LIVE     (MaxLive),
      .ADDR_BITS    (AddrBits)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Allocator model state. It mirrors the block after every accepted item,
   // so a free built from it always names the current top allocation.
   // ------------------------------------------------------------------------
   longint unsigned arena_bytes_q;
   longint unsigned fill_offset_q;
   longint unsigned live_bytes_q;
   longint unsigned rec_start_q [MaxLive];
   longint unsigned rec_size_q  [MaxLive];
   int              rec_count_q;

   // Responses the block owes, oldest first.
   lsa_rsp_type pending_rsp_q [$];

   int mismatch_count;

   // Traffic shaping, in percent of cycles.
   int idle_pct;
   int stall_pct;

   // A nonzero value asks the ready process to hold off for that many cycles.
   int hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TimeoutNs);
      $display("tb_lifo_stack_allocator: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Model of one request. An allocate puts the header at the fill offset,
   // rounds the data up to the requested power of two and fits everything
   // below the usable capacity, which never exceeds the address space. A free
   // only succeeds when its offset plus the top record's size lands exactly
   // on the fill offset.
   // ------------------------------------------------------------------------
   function automatic lsa_rsp_type predict_allocator(input lsa_req_type item);
      longint unsigned start_off;
      longint unsigned data_off;
      longint unsigned pad_mask;
      longint unsigned usable;
      longint unsigned size;
      lsa_rsp_type     rsp;
      rsp        = '0;
      rsp.status = (item.opcode == OP_ALLOC) ? ST_ALLOC_REJECT : ST_FREE_IGNORED;
      if (item.opcode == OP_ALLOC) begin
         size   = 64'(item.request_bytes);
         usable = (arena_bytes_q < (64'd1 << AddrBits)) ? arena_bytes_q
                                                         : (64'd1 << AddrBits);
         if (size != 0 && item.align_log2 <= MAX_ALIGN_LOG2 && rec_count_q < MaxLive) begin
            start_off = fill_offset_q;
            pad_mask  = (64'd1 << item.align_log2) - 64'd1;
            data_off  = (start_off + 64'(HdrBytes) + pad_mask) & ~pad_mask;
            if (data_off + size <= usable) begin
               rec_start_q[rec_count_q] = start_off;
               rec_size_q[rec_count_q]  = size;
               rec_count_q++;
               fill_offset_q      = data_off + size;
               live_bytes_q       = live_bytes_q + size;
               rsp.status         = ST_ALLOCATED;
               rsp.granted_offset = data_off[OffsetWidth-1:0];
            end
         end
      end else if (rec_count_q > 0) begin
         size = rec_size_q[rec_count_q-1];
         if (64'(item.data_offset) + size == fill_offset_q) begin
            fill_offset_q = rec_start_q[rec_count_q-1];
            live_bytes_q  = (live_bytes_q - size) & Mask21;
            rec_count_q--;
            rsp.status    = ST_FREED;
         end
      end
      rsp.top_offset = fill_offset_q[SizeWidth-1:0];
      rsp.used_bytes = live_bytes_q[SizeWidth-1:0];
      return rsp;
   endfunction

   // Data offset of the most recent live allocation, the only one a free can
   // release.
   function automatic logic [OffsetWidth-1:0] top_data_offset();
      longint unsigned off;
      off = 0;
      if (rec_count_q > 0)
         off = fill_offset_q - rec_size_q[rec_count_q-1];
      return off[OffsetWidth-1:0];
   endfunction

   // The fields an operation ignores carry random values, so their bits are
   // exercised too.
   function automatic lsa_req_type make_alloc(input logic [SizeWidth-1:0] size,
                                              input logic [AlignWidth-1:0] align);
      lsa_req_type item;
      item.opcode        = OP_ALLOC;
      item.request_bytes = size;
      item.align_log2    = align;
      item.data_offset   = OffsetWidth'($urandom_range(0, (1 << OffsetWidth) - 1));
      return item;
   endfunction

   function automatic lsa_req_type make_free(input logic [OffsetWidth-1:0] off);
      lsa_req_type item;
      item.opcode        = OP_FREE;
      item.request_bytes = SizeWidth'($urandom_range(0, 1 << 20));
      item.align_log2    = AlignWidth'($urandom_range(0, 15));
      item.data_offset   = off;
      return item;
   endfunction

   // One random request. Most traffic is well-formed: allocations of mostly
   // small sizes and frees of the current top, so the record stack grows and
   // shrinks deeply. The rest is frees that miss the top and pure noise.
   function automatic lsa_req_type random_request();
      int          pick;
      int          size_pick;
      lsa_req_type item;
      pick      = $urandom_range(99);
      size_pick = $urandom_range(99);
      if (pick < 10) begin
         item.opcode        = 1'($urandom_range(0, 1));
         item.request_bytes = SizeWidth'($urandom_range(0, 1 << 20));
         item.align_log2    = AlignWidth'($urandom_range(0, 15));
         item.data_offset   = OffsetWidth'($urandom_range(0, (1 << OffsetWidth) - 1));
      end else if (rec_count_q == 0 || pick < 58) begin
         if (size_pick < 80)
            item = make_alloc(SizeWidth'($urandom_range(1, 64)),
                              AlignWidth'($urandom_range(0, 6)));
         else if (size_pick < 95)
            item = make_alloc(SizeWidth'($urandom_range(65, 8192)),
                              AlignWidth'($urandom_range(0, 12)));
         else
            item = make_alloc(SizeWidth'($urandom_range(8193, 1 << 20)),
                              AlignWidth'($urandom_range(0, 12)));
      end else if (pick < 92) begin
         item = make_free(top_data_offset());
      end else begin
         item = make_free(top_data_offset() ^ (20'd1 << $urandom_range(0, 19)));
      end
      return item;
   endfunction

   // ------------------------------------------------------------------------
   // Sender. An optional idle gap comes first, then the item is offered until
   // the block takes it. Valid stays high afterwards so that back-to-back
   // items need no extra cycle; whoever stops sending lowers it.
   // ------------------------------------------------------------------------
   task automatic send_request(input lsa_req_type item);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_rsp_q.push_back(predict_allocator(item));
   endtask

   // Stops offering items and waits until every owed response has arrived.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // The capacity register is only written while the block is idle.
   task automatic write_arena(input logic [SizeWidth-1:0] bytes);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_wdata <= bytes;
      @(posedge clock);
      csr_we        <= 1'b0;
      arena_bytes_q = 64'(bytes);
   endtask

   task automatic release_all();
      while (rec_count_q > 0)
         send_request(make_free(top_data_offset()));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Rejections, exact fits and free rules on a fresh arena.
   task automatic test_request_edges();
      send_request(make_free(20'd0));                    // nothing is live
      send_request(make_free(20'hF_FFFF));
      send_request(make_alloc(21'd0, 4'd0));             // zero size
      send_request(make_alloc(21'd16, 4'd13));           // alignment too large
      send_request(make_alloc(21'd16, 4'd15));
      send_request(make_alloc(21'h10_0000, 4'd0));       // header pushes it over
      send_request(make_alloc(21'h10_0000 - 21'd4096, 4'd12)); // fills the arena
      send_request(make_alloc(21'd1, 4'd0));             // no room left
      send_request(make_free(top_data_offset() ^ 20'd1)); // misses the top
      send_request(make_free(top_data_offset()));
      send_request(make_alloc(21'd1, 4'd0));
      send_request(make_alloc(21'd3, 4'd4));
      send_request(make_alloc(21'd1000, 4'd12));
      send_request(make_free(20'd8));                    // live, but not the top
      release_all();
      send_request(make_free(20'd0));
   endtask

   // Every alignment exponent, the illegal ones included.
   task automatic test_alignment_sweep();
      for (int a = 0; a < 16; a++)
         send_request(make_alloc(SizeWidth'($urandom_range(1, 300)), AlignWidth'(a)));
      release_all();
   endtask

   // Fill the record stack, try to go past it, then unwind it with a few
   // frees that miss the top mixed in.
   task automatic test_record_stack_full();
      while (rec_count_q < MaxLive)
         send_request(make_alloc(SizeWidth'($urandom_range(1, 32)),
                                 AlignWidth'($urandom_range(0, 3))));
      repeat (3) send_request(make_alloc(SizeWidth'($urandom_range(1, 32)),
                                         AlignWidth'($urandom_range(0, 3))));
      while (rec_count_q > 0) begin
         if ($urandom_range(7) == 0)
            send_request(make_free(top_data_offset() + 20'd1));
         send_request(make_free(top_data_offset()));
      end
   endtask

   // Capacity at its extremes, lowered below the fill offset, and exactly
   // filled by a small arena.
   task automatic test_arena_capacity();
      write_arena(21'd0);
      send_request(make_alloc(21'd1, 4'd0));
      send_request(make_free(20'd0));
      write_arena(ARENA_RESET);
      repeat (4) send_request(make_alloc(SizeWidth'($urandom_range(1, 5000)),
                                         AlignWidth'($urandom_range(0, 12))));
      write_arena(fill_offset_q[SizeWidth-1:0] >> 1);
      send_request(make_alloc(21'd1, 4'd0));
      send_request(make_free(top_data_offset()));
      release_all();
      write_arena(21'd64);
      send_request(make_alloc(21'd56, 4'd0));            // header plus data is 64
      send_request(make_alloc(21'd1, 4'd0));
      send_request(make_free(top_data_offset()));
      send_request(make_alloc(21'd57, 4'd0));            // one byte too many
      write_arena(SizeWidth'($urandom_range(1, 1 << 20)));
      repeat (20) send_request(random_request());
      write_arena(ARENA_RESET);
   endtask

   // The receiver holds off for a long stretch while items keep coming, so
   // the block fills and stalls its input; then the sender pauses until all
   // responses are back.
   task automatic test_backpressure();
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 250;
      repeat (30) send_request(random_request());
      wait_for_results();
   endtask

   // Random traffic in phases of different idle and stall rates, each with
   // its own arena capacity.
   task automatic test_random_traffic();
      int                   idle_by_phase  [4];
      int                   stall_by_phase [4];
      logic [SizeWidth-1:0] arena_by_phase [4];
      idle_by_phase  = '{0, 72, 0, 26};
      stall_by_phase = '{0, 0, 72, 26};
      arena_by_phase = '{ARENA_RESET, 21'd20000,
                         SizeWidth'($urandom_range(1, 1 << 20)), ARENA_RESET};
      for (int p = 0; p < 4; p++) begin
         write_arena(arena_by_phase[p]);
         idle_pct  = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         repeat (75) send_request(random_request());
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver ready. Random stalls follow stall_pct; a hold-off request keeps
   // ready low for the number of cycles asked, counted here.
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response checker. Every accepted response is matched against the oldest
   // owed one; a response nobody asked for also counts as a mismatch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      lsa_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected response st=%0d off=%0h top=%0h used=%0h", $time,
                        rsp_bus.payload.status, rsp_bus.payload.granted_offset,
                        rsp_bus.payload.top_offset, rsp_bus.payload.used_bytes);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_bus.payload.status !== want.status ||
                rsp_bus.payload.granted_offset !== want.granted_offset ||
                rsp_bus.payload.top_offset !== want.top_offset ||
                rsp_bus.payload.used_bytes !== want.used_bytes) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response mismatch, expected st=%0d off=%0h top=%0h used=%0h,",
                           $time, want.status, want.granted_offset, want.top_offset,
                           want.used_bytes, " got st=%0d off=%0h top=%0h used=%0h",
                           rsp_bus.payload.status, rsp_bus.payload.granted_offset,
                           rsp_bus.payload.top_offset, rsp_bus.payload.used_bytes);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      reset           <= 1'b1;

      arena_bytes_q  = 64'(ARENA_RESET);
      fill_offset_q  = 0;
      live_bytes_q   = 0;
      rec_count_q    = 0;
      mismatch_count = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_request   = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_request_edges();
      test_alignment_sweep();
      idle_pct  = 26;
      stall_pct = 26;
      test_record_stack_full();
      test_arena_capacity();
      test_backpressure();
      test_random_traffic();
      wait_for_results();

      if (mismatch_count == 0)
         $display("tb_lifo_stack_allocator: done, clean");
      else
         $display("tb_lifo_stack_allocator: done, errors");
      $finish;
   end

endmodule : tb_lifo_stack_allocator
